// ===== hdl/elev_pkg.sv =====
`timescale 1ns / 1ps

package elev_pkg;

  // building geometry
  localparam int FLW = 4;
  localparam int FLOOR_W = 6;
  localparam int TOP = 10;
  localparam logic [FLW-1:0] TOP_F = FLW'(TOP);
  localparam logic [FLW-1:0] CUR_RST = FLW'(1);

  // input function codes
  localparam logic FUNC_PRESS = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_STOP = 2'd1;
  localparam logic [1:0] DIR_UP = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_HERE = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_PASSING = 3'd3;
  localparam logic [2:0] ST_ARRIVED = 3'd4;
  localparam logic [2:0] ST_NO_REQ = 3'd5;

  // shared unit operations
  localparam logic [1:0] ALU_PASS = 2'd0;
  localparam logic [1:0] ALU_INC = 2'd1;
  localparam logic [1:0] ALU_DEC = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [FLW-1:0] a;
    logic [FLW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [FLW-1:0] res;
    logic lt;
    logic eq;
    logic gt;
  } alu_rsp_t;

endpackage

// ===== hdl/elev_alu.sv =====
`timescale 1ns / 1ps

module elev_alu (
  input  elev_pkg::alu_req_t req,
  output elev_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.res = req.a;
    unique case (req.op)
      elev_pkg::ALU_PASS: rsp.res = req.a;
      elev_pkg::ALU_INC:  rsp.res = req.a + elev_pkg::FLW'(1);
      elev_pkg::ALU_DEC:  rsp.res = req.a - elev_pkg::FLW'(1);
      default:            rsp.res = req.a;
    endcase
    rsp.lt = (req.a < req.b);
    rsp.eq = (req.a == req.b);
    rsp.gt = (req.a > req.b);
  end

endmodule

// ===== hdl/elevator_request_scheduler_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  ports                                        handshake
// in       input      in_func, in_floor                            in_valid / in_ready
// out      output     out_status, out_where, out_heading, out_last out_valid / out_ready
//
// a press gives one beat
// a move is accepted, scans the TOP+1 request bits (one request bit per cycle through the
// shared compare unit), decides, then steps the car floor by floor, one beat per floor
// reset clears all requests, puts the car on floor 1 and sets the direction to stop
// an unaccepted beat holds input and stepping; in_ready is low until a move has finished

module elevator_request_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [elev_pkg::FLOOR_W-1:0] in_floor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [elev_pkg::FLW-1:0]     out_where,
  output logic [1:0]                   out_heading,
  output logic                         out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_STEP = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [elev_pkg::TOP:0] req_r, req_nxt;
  logic [elev_pkg::FLW-1:0] cur_r, cur_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [elev_pkg::FLW-1:0] idx_r, idx_nxt;
  logic up_r, up_nxt;
  logic down_r, down_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [elev_pkg::FLW-1:0] out_where_r, out_where_nxt;
  logic [1:0] out_heading_r, out_heading_nxt;
  logic out_last_r, out_last_nxt;

  logic out_free;
  logic in_fire;
  logic [1:0] new_dir;
  logic at_end;
  elev_pkg::alu_req_t alu_req;
  elev_pkg::alu_rsp_t alu_rsp;

  elev_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_where = out_where_r;
  assign out_heading = out_heading_r;
  assign out_last = out_last_r;

  // scan rule
  always_comb begin
    new_dir = elev_pkg::DIR_STOP;
    if (dir_r == elev_pkg::DIR_UP) begin
      new_dir = up_r ? elev_pkg::DIR_UP : (down_r ? elev_pkg::DIR_DOWN : elev_pkg::DIR_STOP);
    end else if (dir_r == elev_pkg::DIR_DOWN) begin
      new_dir = down_r ? elev_pkg::DIR_DOWN : (up_r ? elev_pkg::DIR_UP : elev_pkg::DIR_STOP);
    end else begin
      new_dir = up_r ? elev_pkg::DIR_UP : (down_r ? elev_pkg::DIR_DOWN : elev_pkg::DIR_STOP);
    end
  end

  // the shared unit compares during the scan and steps the car during travel
  always_comb begin
    alu_req.op = elev_pkg::ALU_PASS;
    alu_req.a = idx_r;
    alu_req.b = cur_r;
    if (state_r == S_STEP) begin
      alu_req.op = (dir_r == elev_pkg::DIR_UP) ? elev_pkg::ALU_INC : elev_pkg::ALU_DEC;
      alu_req.a = cur_r;
      alu_req.b = (dir_r == elev_pkg::DIR_UP) ? elev_pkg::TOP_F : '0;
    end
  end

  assign at_end = (dir_r == elev_pkg::DIR_UP) ? !alu_rsp.lt : alu_rsp.eq;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    cur_nxt = cur_r;
    dir_nxt = dir_r;
    idx_nxt = idx_r;
    up_nxt = up_r;
    down_nxt = down_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_where_nxt = out_where_r;
    out_heading_nxt = out_heading_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == elev_pkg::FUNC_MOVE) begin
            idx_nxt = '0;
            up_nxt = 1'b0;
            down_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_heading_nxt = dir_r;
            out_last_nxt = 1'b1;
            out_where_nxt = cur_r;
            if (in_floor == elev_pkg::FLOOR_W'(cur_r)) begin
              out_status_nxt = elev_pkg::ST_HERE;
            end else if (in_floor > elev_pkg::FLOOR_W'(elev_pkg::TOP)) begin
              out_status_nxt = elev_pkg::ST_INVALID;
            end else begin
              req_nxt[in_floor[elev_pkg::FLW-1:0]] = 1'b1;
              out_status_nxt = elev_pkg::ST_ACCEPTED;
              out_where_nxt = in_floor[elev_pkg::FLW-1:0];
            end
          end
        end
      end
      S_SCAN: begin
        if (req_r[idx_r] && alu_rsp.gt) up_nxt = 1'b1;
        if (req_r[idx_r] && alu_rsp.lt) down_nxt = 1'b1;
        idx_nxt = idx_r + elev_pkg::FLW'(1);
        if (idx_r == elev_pkg::TOP_F) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (new_dir != elev_pkg::DIR_STOP) begin
          dir_nxt = new_dir;
          state_nxt = S_STEP;
        end else if (out_free) begin
          dir_nxt = new_dir;
          out_valid_nxt = 1'b1;
          out_status_nxt = elev_pkg::ST_NO_REQ;
          out_where_nxt = cur_r;
          out_heading_nxt = new_dir;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_STEP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_heading_nxt = dir_r;
          if (at_end) begin
            // shaft end with nothing found, kept for safety
            out_status_nxt = elev_pkg::ST_ARRIVED;
            out_where_nxt = cur_r;
            out_last_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = alu_rsp.res;
            out_where_nxt = alu_rsp.res;
            if (req_r[alu_rsp.res]) begin
              req_nxt[alu_rsp.res] = 1'b0;
              out_status_nxt = elev_pkg::ST_ARRIVED;
              out_last_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              out_status_nxt = elev_pkg::ST_PASSING;
              out_last_nxt = 1'b0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r <= '0;
      cur_r <= elev_pkg::CUR_RST;
      dir_r <= elev_pkg::DIR_STOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_r <= req_nxt;
      cur_r <= cur_nxt;
      dir_r <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    up_r <= up_nxt;
    down_r <= down_nxt;
    out_status_r <= out_status_nxt;
    out_where_r <= out_where_nxt;
    out_heading_r <= out_heading_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= elev_pkg::TOP_F)
    else $error("car floor beyond top floor");

  a_no_req_here: assert property (@(posedge clk) disable iff (!rst_n)
    !req_r[cur_r])
    else $error("request pending on the current floor");

  a_passing_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == elev_pkg::ST_PASSING |->
      out_heading_r != elev_pkg::DIR_STOP && !out_last_r)
    else $error("passing beat while stopped or marked last");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("input ready during a move");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                         func;
    logic [elev_pkg::FLOOR_W-1:0] floor;
  } cmd_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [elev_pkg::FLW-1:0] where;
    logic [1:0]               heading;
    logic                     last;
  } report_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_func;
  logic [elev_pkg::FLOOR_W-1:0] in_floor;
  logic                         out_valid;
  logic                         out_ready;
  logic [2:0]                   out_status;
  logic [elev_pkg::FLW-1:0]     out_where;
  logic [1:0]                   out_heading;
  logic                         out_last;

  cmd_t    cmd_q[$];
  report_t car_reports_q[$];

  // car state as seen by the scoreboard
  bit                       hall_req [0:elev_pkg::TOP];
  logic [elev_pkg::FLW-1:0] car_floor;
  logic [1:0]               car_dir;

  int n_total;
  int n_acc;
  int n_fail;
  int idle_in_pct;
  int idle_out_pct;

  elevator_request_scheduler_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_floor    (in_floor),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_where   (out_where),
    .out_heading (out_heading),
    .out_last    (out_last)
  );

  always #1 clk = ~clk;

  // one scan controller step: queues every report the command causes
  function automatic void scan_step(input cmd_t c);
    bit up_req;
    bit dn_req;
    int f;
    int s;
    up_req = 1'b0;
    dn_req = 1'b0;
    if (c.func == elev_pkg::FUNC_PRESS) begin
      if (c.floor == elev_pkg::FLOOR_W'(car_floor)) begin
        car_reports_q.push_back(report_t'{elev_pkg::ST_HERE, car_floor, car_dir, 1'b1});
      end else if (c.floor > elev_pkg::FLOOR_W'(elev_pkg::TOP)) begin
        car_reports_q.push_back(report_t'{elev_pkg::ST_INVALID, car_floor, car_dir, 1'b1});
      end else begin
        hall_req[c.floor] = 1'b1;
        car_reports_q.push_back(report_t'{elev_pkg::ST_ACCEPTED,
                                          elev_pkg::FLW'(c.floor), car_dir, 1'b1});
      end
      return;
    end
    for (f = 0; f <= elev_pkg::TOP; f++) begin
      if (hall_req[f] && f > int'(car_floor)) up_req = 1'b1;
      if (hall_req[f] && f < int'(car_floor)) dn_req = 1'b1;
    end
    if (car_dir == elev_pkg::DIR_UP) begin
      if (!up_req) car_dir = dn_req ? elev_pkg::DIR_DOWN : elev_pkg::DIR_STOP;
    end else if (car_dir == elev_pkg::DIR_DOWN) begin
      if (!dn_req) car_dir = up_req ? elev_pkg::DIR_UP : elev_pkg::DIR_STOP;
    end else begin
      car_dir = up_req ? elev_pkg::DIR_UP
                       : (dn_req ? elev_pkg::DIR_DOWN : elev_pkg::DIR_STOP);
    end
    if (car_dir == elev_pkg::DIR_STOP) begin
      car_reports_q.push_back(report_t'{elev_pkg::ST_NO_REQ, car_floor, car_dir, 1'b1});
      return;
    end
    for (s = 0; s <= elev_pkg::TOP; s++) begin
      if (car_dir == elev_pkg::DIR_UP) begin
        if (car_floor >= elev_pkg::TOP_F) break;
        car_floor = car_floor + 1'b1;
      end else begin
        if (car_floor == '0) break;
        car_floor = car_floor - 1'b1;
      end
      if (hall_req[car_floor]) begin
        hall_req[car_floor] = 1'b0;
        car_reports_q.push_back(report_t'{elev_pkg::ST_ARRIVED, car_floor, car_dir, 1'b1});
        return;
      end
      car_reports_q.push_back(report_t'{elev_pkg::ST_PASSING, car_floor, car_dir, 1'b0});
    end
    car_reports_q.push_back(report_t'{elev_pkg::ST_ARRIVED, car_floor, car_dir, 1'b1});
  endfunction

  // idle mix follows progress through the item list
  always_comb begin
    if (n_acc < n_total / 3) begin
      idle_in_pct  = 11;
      idle_out_pct = 70;
    end else if (n_acc < (2 * n_total) / 3) begin
      idle_in_pct  = 70;
      idle_out_pct = 11;
    end else begin
      idle_in_pct  = 0;
      idle_out_pct = 0;
    end
  end

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_step(cmd_t'{in_func, in_floor});
        n_acc <= n_acc + 1;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          c = cmd_q.pop_front();
          in_func  <= c.func;
          in_floor <= c.floor;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = report_t'{out_status, out_where, out_heading, out_last};
        if (car_reports_q.size() == 0) begin
          n_fail <= n_fail + 1;
          if (n_fail < 10)
            $display("unexpected beat: status=%0d where=%0d heading=%0d last=%0d",
                     got.status, got.where, got.heading, got.last);
        end else begin
          want = car_reports_q.pop_front();
          if (got !== want) begin
            n_fail <= n_fail + 1;
            if (n_fail < 10)
              $display("mismatch: exp status=%0d where=%0d heading=%0d last=%0d,",
                       want.status, want.where, want.heading, want.last,
                       " got status=%0d where=%0d heading=%0d last=%0d",
                       got.status, got.where, got.heading, got.last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  task automatic add_cmd(input logic func, input int floor);
    cmd_q.push_back(cmd_t'{func, elev_pkg::FLOOR_W'(floor)});
  endtask

  initial begin
    int r;
    int k;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = elev_pkg::FUNC_PRESS;
    in_floor  = '0;
    out_ready = 1'b0;
    n_acc     = 0;
    n_fail    = 0;
    car_floor = elev_pkg::CUR_RST;
    car_dir   = elev_pkg::DIR_STOP;
    for (k = 0; k <= elev_pkg::TOP; k++) hall_req[k] = 1'b0;

    // directed walk: car starts on floor 1, stopped
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // nothing requested
    add_cmd(elev_pkg::FUNC_PRESS, 1);   // press on the current floor
    add_cmd(elev_pkg::FUNC_PRESS, 63);
    add_cmd(elev_pkg::FUNC_PRESS, elev_pkg::TOP + 1);
    add_cmd(elev_pkg::FUNC_PRESS, 42);
    add_cmd(elev_pkg::FUNC_PRESS, 21);
    add_cmd(elev_pkg::FUNC_PRESS, 0);
    add_cmd(elev_pkg::FUNC_PRESS, elev_pkg::TOP);
    add_cmd(elev_pkg::FUNC_PRESS, 5);
    add_cmd(elev_pkg::FUNC_MOVE, 63);   // start up, stop at 5
    add_cmd(elev_pkg::FUNC_PRESS, 2);
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // keep going up to the top
    add_cmd(elev_pkg::FUNC_PRESS, elev_pkg::TOP); // already at the top
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // reverse, down to 2
    add_cmd(elev_pkg::FUNC_PRESS, 2);
    add_cmd(elev_pkg::FUNC_PRESS, 9);
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // keep going down to 0
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // reverse, up to 9
    add_cmd(elev_pkg::FUNC_PRESS, elev_pkg::TOP);
    add_cmd(elev_pkg::FUNC_PRESS, 0);
    add_cmd(elev_pkg::FUNC_MOVE, 0);
    add_cmd(elev_pkg::FUNC_MOVE, 0);    // full run from the top down to 0
    add_cmd(elev_pkg::FUNC_MOVE, 0);

    for (k = 0; k < 440; k++) begin
      r = $urandom_range(99);
      if (r < 55)
        add_cmd(elev_pkg::FUNC_PRESS, $urandom_range(elev_pkg::TOP));
      else if (r < 63)
        add_cmd(elev_pkg::FUNC_PRESS, $urandom_range(63, elev_pkg::TOP + 1));
      else
        add_cmd(elev_pkg::FUNC_MOVE, $urandom_range(63));
    end
    n_total = cmd_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_valid || car_reports_q.size() > 0) @(posedge clk);
    // a move scans all TOP+1 request bits and travels before its beats
    repeat (4 * elev_pkg::TOP + 20) @(posedge clk);

    if (n_fail == 0 && car_reports_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/elev_pkg.sv
hdl/elev_alu.sv
hdl/elevator_request_scheduler_unit.sv
test/tb_top.sv
